/* hw/rtl/fractal_value_noise_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for fractal_value_noise
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define FVN_ASSERT_NOW(lbl, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
        else $error("fractal_value_noise: check failed");
// Next-cycle implication check.
`define FVN_ASSERT_NEXT(lbl, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("fractal_value_noise: check failed");
`else
`define FVN_ASSERT_NOW(lbl, cond, res)
`define FVN_ASSERT_NEXT(lbl, cond, res)
`endif
`endif

/* hw/rtl/fvn_pkg.sv */
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared types, hash constants and register codes of the fractal noise block.
// ----------------------------------------------------------------------------
package fvn_pkg;

    // Avalanche hash constants.
    localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;
    localparam logic [31:0] X_OFFSET   = 32'h9e3779b9;
    localparam logic [31:0] Z_OFFSET   = 32'h85ebca6b;

    // Per-octave seed steps.
    localparam int SEED_STEP_PLAIN = 131;
    localparam int SEED_STEP_RIDGE = 193;

    // Fixed-point formats of corner values and of the result.
    localparam int VAL_FRAC = 23;
    localparam int OUT_FRAC = 16;
    localparam int VAL_W    = VAL_FRAC + 1;
    localparam int QUOT_W   = OUT_FRAC + 1;
    localparam int OUT_W    = 18;
    localparam int OCT_W    = 5;

    // Register indexes.
    localparam logic [1:0] REG_SEED   = 2'd0;
    localparam logic [1:0] REG_OCTAVE = 2'd1;
    localparam logic [1:0] REG_RIDGE  = 2'd2;

    // Configuration seen by the octave cells and the divider.
    typedef struct packed {
        logic [31:0]      seed;
        logic             ridge;
        logic [OCT_W-1:0] octaves;
    } cfg_t;

    // Xor-shift steps of the hash.
    function automatic logic [31:0] fold16(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [31:0] fold15(input logic [31:0] v);
        return v ^ (v >> 15);
    endfunction

endpackage

/* hw/rtl/fvn_cell.sv */
// ----------------------------------------------------------------------------
// fvn_cell
// One octave of the noise sum: lattice hash, smoothstep, bilinear blend and
// the running total, in seven stages. Cells are chained, one per octave.
// ----------------------------------------------------------------------------
module fvn_cell #(
    parameter int OCT   = 0,
    parameter int FB    = 16,
    parameter int ACC_W = 33
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  fvn_pkg::cfg_t           cfg,
    input  logic                    in_valid,
    input  logic [31:0]             in_x,
    input  logic [31:0]             in_z,
    input  logic signed [ACC_W-1:0] in_acc,
    output logic                    out_valid,
    output logic [31:0]             out_x,
    output logic [31:0]             out_z,
    output logic signed [ACC_W-1:0] out_acc
);

    localparam int VW   = fvn_pkg::VAL_W;
    localparam int LP_W = VW + FB + 3;
    localparam int SW   = FB + 32;
    localparam logic [31:0] SEED_P = 32'(OCT * fvn_pkg::SEED_STEP_PLAIN);
    localparam logic [31:0] SEED_R = 32'(OCT * fvn_pkg::SEED_STEP_RIDGE);
    localparam logic [FB:0] ONE    = (FB + 1)'(1) << FB;
    localparam logic [FB+1:0] THREE = (FB + 2)'(3) << FB;
    localparam logic signed [VW:0] VAL_ONE = (VW + 1)'(1) << fvn_pkg::VAL_FRAC;

    // Bilinear step with a floor shift back to the value format.
    function automatic logic signed [VW-1:0] lerp(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b,
                                                  input logic [FB:0] s);
        logic signed [FB+1:0]   wa;
        logic signed [FB+1:0]   wb;
        logic signed [LP_W-1:0] p;
        wa = $signed({1'b0, ONE - s});
        wb = $signed({1'b0, s});
        p  = a * wa + b * wb;
        return VW'(p >>> FB);
    endfunction

    // Smoothstep of the second stage.
    function automatic logic [FB:0] smooth(input logic [FB-1:0] f,
                                           input logic [FB-1:0] f2);
        logic [FB+1:0]   t;
        logic [2*FB+1:0] p;
        t = THREE - {1'b0, f, 1'b0};
        p = f2 * t;
        return p[2*FB:FB];
    endfunction

    logic [31:0] seed;
    assign seed = cfg.seed + (cfg.ridge ? SEED_R : SEED_P);

    // Stage valid bits.
    logic [6:0] v_reg;

    // Stage 1: lattice split, first x hash multiply, fraction squares.
    logic [SW-1:0]   xs, zs;
    logic [31:0]     ix, iz_next;
    logic [FB-1:0]   fx_next, fz_next;
    logic [2*FB-1:0] fxx, fzz;
    logic [31:0]     xa_next [2];
    logic [31:0]     xa_reg [2];
    logic [31:0]     iz_reg;
    logic [FB-1:0]   fx_reg, fz_reg, f2x_reg, f2z_reg;
    logic [31:0]     x1_reg, z1_reg;
    logic signed [ACC_W-1:0] acc1_reg;

    always_comb
    begin
        xs = SW'({{FB{in_x[31]}}, in_x}) << OCT;
        zs = SW'({{FB{in_z[31]}}, in_z}) << OCT;
        ix = xs[FB+31:FB];
        iz_next = zs[FB+31:FB];
        fx_next = xs[FB-1:0];
        fz_next = zs[FB-1:0];
        fxx = fx_next * fx_next;
        fzz = fz_next * fz_next;
        xa_next[0] = fvn_pkg::fold16(ix + fvn_pkg::X_OFFSET) * fvn_pkg::HASH_MUL_A;
        xa_next[1] = fvn_pkg::fold16(ix + 32'd1 + fvn_pkg::X_OFFSET) * fvn_pkg::HASH_MUL_A;
    end

    // Stage 2: second x hash multiply, smoothstep.
    logic [31:0] xb_next [2];
    logic [31:0] xb_reg [2];
    logic [31:0] iz2_reg, x2_reg, z2_reg;
    logic [FB:0] sx_reg, sz_reg;
    logic signed [ACC_W-1:0] acc2_reg;

    always_comb
    begin
        xb_next[0] = fvn_pkg::fold15(xa_reg[0]) * fvn_pkg::HASH_MUL_B;
        xb_next[1] = fvn_pkg::fold15(xa_reg[1]) * fvn_pkg::HASH_MUL_B;
    end

    // Stage 3: seed mix, first z hash multiply for the four corners.
    // Corner j takes x+1 when bit 0 is set and z+1 when bit 1 is set.
    logic [31:0] h_next [4];
    logic [31:0] za_next [4];
    logic [31:0] h_reg [4];
    logic [31:0] za_reg [4];
    logic [31:0] x3_reg, z3_reg;
    logic [FB:0] sx3_reg, sz3_reg;
    logic signed [ACC_W-1:0] acc3_reg;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            h_next[j]  = seed ^ fvn_pkg::fold16(xb_reg[j % 2]);
            za_next[j] = fvn_pkg::fold16(iz2_reg + 32'(j / 2) + fvn_pkg::Z_OFFSET
                                         + h_next[j]) * fvn_pkg::HASH_MUL_A;
        end
    end

    // Stage 4: second z hash multiply.
    logic [31:0] zb_next [4];
    logic [31:0] zb_reg [4];
    logic [31:0] h4_reg [4];
    logic [31:0] x4_reg, z4_reg;
    logic [FB:0] sx4_reg, sz4_reg;
    logic signed [ACC_W-1:0] acc4_reg;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            zb_next[j] = fvn_pkg::fold15(za_reg[j]) * fvn_pkg::HASH_MUL_B;
        end
    end

    // Stage 5: corner values and the blend along x.
    logic [31:0]            hf [4];
    logic signed [VW-1:0]   c [4];
    logic signed [VW-1:0]   l0_reg, l1_reg;
    logic [31:0]            x5_reg, z5_reg;
    logic [FB:0]            sz5_reg;
    logic signed [ACC_W-1:0] acc5_reg;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            hf[j] = h4_reg[j] ^ fvn_pkg::fold16(zb_reg[j]);
            c[j]  = $signed({~hf[j][VW-1], hf[j][VW-2:0]});
        end
    end

    // Stage 6: blend along z.
    logic signed [VW-1:0]    n_reg;
    logic [31:0]             x6_reg, z6_reg;
    logic signed [ACC_W-1:0] acc6_reg;

    // Stage 7: octave term and running total.
    logic signed [VW:0]      n_ext, n_abs, term;
    logic signed [ACC_W-1:0] acc_next, acc7_reg;
    logic [31:0]             x7_reg, z7_reg;

    always_comb
    begin
        n_ext = (VW + 1)'(n_reg);
        n_abs = n_ext[VW] ? -n_ext : n_ext;
        term  = cfg.ridge ? VAL_ONE - n_abs : n_ext;
        if (fvn_pkg::OCT_W'(OCT) < cfg.octaves)
        begin
            acc_next = (acc6_reg <<< 1) + ACC_W'(term);
        end
        else
        begin
            acc_next = acc6_reg;
        end
    end

    // Valid bits advance with the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg  <= xa_next;
            iz_reg  <= iz_next;
            fx_reg  <= fx_next;
            fz_reg  <= fz_next;
            f2x_reg <= fxx[2*FB-1:FB];
            f2z_reg <= fzz[2*FB-1:FB];
            x1_reg  <= in_x;
            z1_reg  <= in_z;
            acc1_reg <= in_acc;

            xb_reg  <= xb_next;
            iz2_reg <= iz_reg;
            sx_reg  <= smooth(fx_reg, f2x_reg);
            sz_reg  <= smooth(fz_reg, f2z_reg);
            x2_reg  <= x1_reg;
            z2_reg  <= z1_reg;
            acc2_reg <= acc1_reg;

            h_reg   <= h_next;
            za_reg  <= za_next;
            sx3_reg <= sx_reg;
            sz3_reg <= sz_reg;
            x3_reg  <= x2_reg;
            z3_reg  <= z2_reg;
            acc3_reg <= acc2_reg;

            zb_reg  <= zb_next;
            h4_reg  <= h_reg;
            sx4_reg <= sx3_reg;
            sz4_reg <= sz3_reg;
            x4_reg  <= x3_reg;
            z4_reg  <= z3_reg;
            acc4_reg <= acc3_reg;

            l0_reg  <= lerp(c[0], c[1], sx4_reg);
            l1_reg  <= lerp(c[2], c[3], sx4_reg);
            sz5_reg <= sz4_reg;
            x5_reg  <= x4_reg;
            z5_reg  <= z4_reg;
            acc5_reg <= acc4_reg;

            n_reg   <= lerp(l0_reg, l1_reg, sz5_reg);
            x6_reg  <= x5_reg;
            z6_reg  <= z5_reg;
            acc6_reg <= acc5_reg;

            acc7_reg <= acc_next;
            x7_reg  <= x6_reg;
            z7_reg  <= z6_reg;
        end
    end

    assign out_valid = v_reg[6];
    assign out_x     = x7_reg;
    assign out_z     = z7_reg;
    assign out_acc   = acc7_reg;

endmodule

/* hw/rtl/fvn_div.sv */
// ----------------------------------------------------------------------------
// fvn_div
// Normalizing divider: rounds |total| / ((2^K - 1) * 2^7) to nearest, one
// quotient bit per pipeline stage, then restores the sign.
// ----------------------------------------------------------------------------
module fvn_div #(
    parameter int ACC_W = 33,
    parameter int MAX_O = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  fvn_pkg::cfg_t            cfg,
    input  logic                     in_valid,
    input  logic signed [ACC_W-1:0]  in_acc,
    output logic                     out_valid,
    output logic [fvn_pkg::OUT_W-1:0] out_value
);

    localparam int QW = fvn_pkg::QUOT_W;
    localparam int DW = MAX_O + fvn_pkg::VAL_FRAC - fvn_pkg::OUT_FRAC;
    localparam int CW = ACC_W + QW;
    localparam int SH = fvn_pkg::VAL_FRAC - fvn_pkg::OUT_FRAC;

    // Preparation: magnitude plus half the divisor.
    logic [DW-1:0]    d_next;
    logic [ACC_W-1:0] mag;
    logic             p_v_reg;
    logic [ACC_W-1:0] p_rem_reg;
    logic [DW-1:0]    p_d_reg;
    logic             p_neg_reg, p_zero_reg;

    always_comb
    begin
        d_next = ((DW'(1) << cfg.octaves) - DW'(1)) << SH;
        mag    = in_acc[ACC_W-1] ? ACC_W'(-in_acc) : ACC_W'(in_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rem_reg  <= mag + ACC_W'(d_next >> 1);
            p_d_reg    <= d_next;
            p_neg_reg  <= in_acc[ACC_W-1];
            p_zero_reg <= (cfg.octaves == '0);
        end
    end

    // Restoring stages, most significant quotient bit first.
    logic             s_v   [QW+1];
    logic [ACC_W-1:0] s_rem [QW+1];
    logic [DW-1:0]    s_d   [QW+1];
    logic [QW-1:0]    s_q   [QW+1];
    logic             s_neg [QW+1];
    logic             s_zero[QW+1];

    assign s_v[0]    = p_v_reg;
    assign s_rem[0]  = p_rem_reg;
    assign s_d[0]    = p_d_reg;
    assign s_q[0]    = '0;
    assign s_neg[0]  = p_neg_reg;
    assign s_zero[0] = p_zero_reg;

    for (genvar t = 0; t < QW; t++)
    begin : g_stage
        localparam int BIT = QW - 1 - t;
        logic [CW-1:0]    dsh;
        logic             ge;
        logic [ACC_W-1:0] rem_next;
        logic [QW-1:0]    q_next;
        logic             v_reg, neg_reg, zero_reg;
        logic [ACC_W-1:0] rem_reg;
        logic [DW-1:0]    d_reg;
        logic [QW-1:0]    q_reg;

        always_comb
        begin
            dsh      = CW'(s_d[t]) << BIT;
            ge       = CW'(s_rem[t]) >= dsh;
            rem_next = ge ? ACC_W'(CW'(s_rem[t]) - dsh) : s_rem[t];
            q_next   = s_q[t] | (QW'(ge) << BIT);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= s_v[t];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                d_reg    <= s_d[t];
                q_reg    <= q_next;
                neg_reg  <= s_neg[t];
                zero_reg <= s_zero[t];
            end
        end

        assign s_v[t+1]    = v_reg;
        assign s_rem[t+1]  = rem_reg;
        assign s_d[t+1]    = d_reg;
        assign s_q[t+1]    = q_reg;
        assign s_neg[t+1]  = neg_reg;
        assign s_zero[t+1] = zero_reg;
    end

    // Sign and the zero-octave case.
    logic [fvn_pkg::OUT_W-1:0] q_ext;
    assign q_ext     = fvn_pkg::OUT_W'(s_q[QW]);
    assign out_valid = s_v[QW];
    assign out_value = s_zero[QW] ? '0 : (s_neg[QW] ? -q_ext : q_ext);

endmodule

/* hw/rtl/fractal_value_noise.sv */
// ----------------------------------------------------------------------------
// fractal_value_noise
// Fractal value noise of a 2-D Q16.16 point: a chain of octave cells feeds
// a pipelined normalizing divider and a two-entry output buffer.
//
//   Channel   Direction  Beat contents
//   s_axis    in         x_coord, z_coord
//   m_axis    out        noise_value
//   cfg       in         register index and write data
//
// One point is taken per clock cycle while the skid register is empty.
// Each point passes every octave cell, the divider and the output register.
// The hash multiplies of each cell set the stage count of the chain.
// Reset clears only valid bits and sets the configuration registers to defaults.
// A stalled output holds one extra result in a skid register; input is
// refused only while that register is full.
// ----------------------------------------------------------------------------
`include "fractal_value_noise_assert.svh"

module fractal_value_noise #(
    parameter int MAX_OCTAVES   = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] x_coord, [63:32] z_coord
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [17:0] noise_value, [23:18] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ACC_W = fvn_pkg::VAL_W + MAX_OCTAVES + 1;
    localparam int OW    = fvn_pkg::OUT_W;

    // Configuration registers.
    logic [31:0] seed_reg;
    logic [3:0]  octave_reg;
    logic        ridge_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= 32'h12345678;
            octave_reg <= 4'd1;
            ridge_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fvn_pkg::REG_SEED:   seed_reg   <= cfg_data;
                fvn_pkg::REG_OCTAVE: octave_reg <= cfg_data[3:0];
                fvn_pkg::REG_RIDGE:  ridge_reg  <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Octave count saturated to the chain length.
    fvn_pkg::cfg_t cfg;
    always_comb
    begin
        cfg.seed    = seed_reg;
        cfg.ridge   = ridge_reg;
        cfg.octaves = (fvn_pkg::OCT_W'(octave_reg) > fvn_pkg::OCT_W'(MAX_OCTAVES))
                      ? fvn_pkg::OCT_W'(MAX_OCTAVES) : fvn_pkg::OCT_W'(octave_reg);
    end

    // The whole pipeline moves while the skid register is empty.
    logic en;
    logic skid_valid_reg;
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // Octave chain.
    logic                    ch_v   [MAX_OCTAVES+1];
    logic [31:0]             ch_x   [MAX_OCTAVES+1];
    logic [31:0]             ch_z   [MAX_OCTAVES+1];
    logic signed [ACC_W-1:0] ch_acc [MAX_OCTAVES+1];

    assign ch_v[0]   = s_axis_tvalid;
    assign ch_x[0]   = s_axis_tdata[31:0];
    assign ch_z[0]   = s_axis_tdata[63:32];
    assign ch_acc[0] = '0;

    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_cell
        fvn_cell #(
            .OCT   (i),
            .FB    (FRACTION_BITS),
            .ACC_W (ACC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .cfg       (cfg),
            .in_valid  (ch_v[i]),
            .in_x      (ch_x[i]),
            .in_z      (ch_z[i]),
            .in_acc    (ch_acc[i]),
            .out_valid (ch_v[i+1]),
            .out_x     (ch_x[i+1]),
            .out_z     (ch_z[i+1]),
            .out_acc   (ch_acc[i+1])
        );
    end

    // Normalization.
    logic          div_valid;
    logic [OW-1:0] div_value;

    fvn_div #(
        .ACC_W (ACC_W),
        .MAX_O (MAX_OCTAVES)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (ch_v[MAX_OCTAVES]),
        .in_acc    (ch_acc[MAX_OCTAVES]),
        .out_valid (div_valid),
        .out_value (div_value)
    );

    // Output register with a skid register behind it.
    logic          done;
    logic          out_valid_reg;
    logic [OW-1:0] out_value_reg, skid_value_reg;

    assign done = div_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg  <= skid_valid_reg || done;
            skid_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            out_value_reg <= skid_valid_reg ? skid_value_reg : div_value;
        end
        else if (done)
        begin
            skid_value_reg <= div_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_value_reg};

    // The skid register fills only behind a waiting output beat.
    `FVN_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `FVN_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_axis_tready, skid_valid_reg)
    `FVN_ASSERT_NEXT(a_skid_catches, out_valid_reg && !m_axis_tready && done, skid_valid_reg)

endmodule
